### rtl/core/slr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stopwatch with lap recall.
// No dependencies; imported by every module of the block.
package slr_pkg;

   localparam int unsigned LAP_SLOTS_DEF = 5;
   localparam logic [15:0] TPS_RESET = 16'd1000;

   // one poll: tick and three active-low button levels
   typedef struct packed {
      logic tick;
      logic start_pin;
      logic lap_pin;
      logic recall_pin;
   } req_type;

   // displayed digits plus redraw flag
   typedef struct packed {
      logic [6:0] tens_minutes;
      logic [3:0] minutes_digit;
      logic [2:0] tens_seconds;
      logic [3:0] seconds_digit;
      logic       refresh;
   } rsp_type;

   // count after the poll, handed from the control core to the digit splitter
   typedef struct packed {
      logic [15:0] seconds;
      logic        refresh;
   } count_type;

endpackage

### rtl/core/slr_core.sv
`timescale 1ns / 1ps
// Stopwatch control: button edge latches, tick prescaler, seconds counter, lap store.
// Depends on slr_pkg. Produces one registered count per accepted poll.
module slr_core #(
   parameter int unsigned LAP_SLOTS = slr_pkg::LAP_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  slr_pkg::req_type   req_data,
   output logic               cnt_valid,
   input  logic               cnt_ready,
   output slr_pkg::count_type cnt_data
);
   import slr_pkg::*;

   localparam int unsigned IdxW  = $clog2(LAP_SLOTS + 1);
   localparam int unsigned AddrW = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
   localparam logic [IdxW-1:0] SlotsEnd = IdxW'(LAP_SLOTS);
   localparam logic [IdxW-1:0] IdxOne   = IdxW'(1);

   logic [15:0]     tps_ff;
   logic [15:0]     tick_count_ff, tick_count_in;
   logic [15:0]     seconds_ff, seconds_in;
   logic            running_ff, running_in;
   logic [1:0]      press_phase_ff, press_phase_in;
   logic [IdxW-1:0] lap_index_ff, lap_index_in;
   logic [IdxW-1:0] saved_index_ff, saved_index_in;
   logic [2:0]      latch_ff, latch_in;
   logic [15:0]     store_ff [LAP_SLOTS];
   logic            store_we;
   logic [AddrW-1:0] store_waddr;
   logic            refresh_c;
   logic            accept;
   logic            out_valid_ff;
   count_type       out_data_ff;

   logic start_low, lap_low, recall_low;

   assign csr_ready = 1'b1;
   assign req_ready = !out_valid_ff || cnt_ready;
   assign accept    = req_valid && req_ready;
   assign cnt_valid = out_valid_ff;
   assign cnt_data  = out_data_ff;

   assign start_low  = !req_data.start_pin;
   assign lap_low    = !req_data.lap_pin;
   assign recall_low = !req_data.recall_pin;

   always_comb begin
      tick_count_in  = tick_count_ff;
      seconds_in     = seconds_ff;
      running_in     = running_ff;
      press_phase_in = press_phase_ff;
      lap_index_in   = lap_index_ff;
      saved_index_in = saved_index_ff;
      latch_in       = latch_ff;
      store_we       = 1'b0;
      store_waddr    = lap_index_ff[AddrW-1:0];
      refresh_c      = 1'b0;

      // start/stop press toggles running; a stop parks the lap index
      if (start_low && !latch_ff[0]) begin
         tick_count_in  = '0;
         press_phase_in = press_phase_ff + 2'd1;
         if (running_ff) begin
            saved_index_in = lap_index_ff;
            lap_index_in   = '0;
            running_in     = 1'b0;
         end else begin
            running_in = 1'b1;
         end
      end
      latch_in[0] = start_low;

      if (lap_low && !latch_ff[1] && lap_index_in < SlotsEnd) begin
         store_we     = 1'b1;
         store_waddr  = lap_index_in[AddrW-1:0];
         lap_index_in = lap_index_in + IdxOne;
      end
      latch_in[1] = lap_low;

      // prescaler saturates at the threshold
      if (req_data.tick && tick_count_in < tps_ff) begin
         tick_count_in = tick_count_in + 16'd1;
      end
      if (running_in && tick_count_in >= tps_ff) begin
         tick_count_in = '0;
         seconds_in    = seconds_ff + 16'd1;
         refresh_c     = 1'b1;
      end

      // every restart after the first resumes lap numbering
      if (press_phase_in == 2'd3) begin
         lap_index_in   = saved_index_in;
         press_phase_in = 2'd1;
      end

      // recall only while stopped; latch frozen while running.
      // The read slot is never the one written by a lap press in the same poll.
      if (!running_in) begin
         if (recall_low && !latch_ff[2]) begin
            if (lap_index_in < SlotsEnd) begin
               seconds_in   = store_ff[lap_index_in[AddrW-1:0]];
               lap_index_in = lap_index_in + IdxOne;
            end
            refresh_c = 1'b1;
         end
         latch_in[2] = recall_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff         <= TPS_RESET;
         tick_count_ff  <= '0;
         seconds_ff     <= '0;
         running_ff     <= 1'b0;
         press_phase_ff <= '0;
         lap_index_ff   <= '0;
         saved_index_ff <= '0;
         latch_ff       <= '0;
         out_valid_ff   <= 1'b0;
         for (int i = 0; i < LAP_SLOTS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            tps_ff <= csr_wdata;
         end
         if (accept) begin
            tick_count_ff  <= tick_count_in;
            seconds_ff     <= seconds_in;
            running_ff     <= running_in;
            press_phase_ff <= press_phase_in;
            lap_index_ff   <= lap_index_in;
            saved_index_ff <= saved_index_in;
            latch_ff       <= latch_in;
            if (store_we) begin
               store_ff[store_waddr] <= seconds_ff;
            end
         end
         if (req_ready) begin
            out_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_data_ff.seconds <= seconds_in;
         out_data_ff.refresh <= refresh_c;
      end
   end

endmodule

### rtl/core/slr_digits.sv
`timescale 1ns / 1ps
// Three-stage split of the seconds count into m10:m:s10:s digits.
// Depends on slr_pkg. Divisions use reciprocal multiplies, exact over 16-bit counts.
module slr_digits (
   input  logic               clock,
   input  logic               reset,
   input  logic               cnt_valid,
   output logic               cnt_ready,
   input  slr_pkg::count_type cnt_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output slr_pkg::rsp_type   rsp_data
);
   import slr_pkg::*;

   // floor(x/d) = (x * M) >> K for the input ranges used here
   localparam logic [16:0] Recip600 = 17'd111849; // K = 26, x < 2^16
   localparam logic [10:0] Recip60  = 11'd1093;   // K = 16, x < 600
   localparam logic [4:0]  Recip10  = 5'd26;      // K = 8,  x < 60

   logic va_ff, vb_ff, vc_ff;
   logic adv_a, adv_b, adv_c;

   // stage A
   logic [32:0] prod_a;
   logic [6:0]  q600_c;
   logic [15:0] q600_x600;
   logic [15:0] rem600_full;
   logic [6:0]  tm_a_ff;
   logic [9:0]  rem600_a_ff;
   logic        ref_a_ff;

   // stage B
   logic [20:0] prod_b;
   logic [3:0]  m_c;
   logic [9:0]  m_x60;
   logic [9:0]  rem60_full;
   logic [6:0]  tm_b_ff;
   logic [3:0]  m_b_ff;
   logic [5:0]  rem60_b_ff;
   logic        ref_b_ff;

   // stage C
   logic [10:0] prod_c;
   logic [2:0]  s10_c;
   logic [5:0]  s10_x10;
   logic [5:0]  sd_full;
   rsp_type     out_ff;

   assign adv_c     = !vc_ff || rsp_ready;
   assign adv_b     = !vb_ff || adv_c;
   assign adv_a     = !va_ff || adv_b;
   assign cnt_ready = adv_a;
   assign rsp_valid = vc_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      prod_a      = {17'd0, cnt_data.seconds} * {16'd0, Recip600};
      q600_c      = prod_a[32:26];
      // q * 600 as shifts: 512 + 64 + 16 + 8
      q600_x600   = ({9'd0, q600_c} << 9) + ({9'd0, q600_c} << 6)
                  + ({9'd0, q600_c} << 4) + ({9'd0, q600_c} << 3);
      rem600_full = cnt_data.seconds - q600_x600;

      prod_b      = {11'd0, rem600_a_ff} * {10'd0, Recip60};
      m_c         = prod_b[19:16];
      // m * 60 as shifts: 32 + 16 + 8 + 4
      m_x60       = ({6'd0, m_c} << 5) + ({6'd0, m_c} << 4)
                  + ({6'd0, m_c} << 3) + ({6'd0, m_c} << 2);
      rem60_full  = rem600_a_ff - m_x60;

      prod_c      = {5'd0, rem60_b_ff} * {6'd0, Recip10};
      s10_c       = prod_c[10:8];
      s10_x10     = ({3'd0, s10_c} << 3) + ({3'd0, s10_c} << 1);
      sd_full     = rem60_b_ff - s10_x10;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            va_ff <= cnt_valid;
         end
         if (adv_b) begin
            vb_ff <= va_ff;
         end
         if (adv_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         tm_a_ff     <= q600_c;
         rem600_a_ff <= rem600_full[9:0];
         ref_a_ff    <= cnt_data.refresh;
      end
      if (adv_b) begin
         tm_b_ff    <= tm_a_ff;
         m_b_ff     <= m_c;
         rem60_b_ff <= rem60_full[5:0];
         ref_b_ff   <= ref_a_ff;
      end
      if (adv_c) begin
         out_ff.tens_minutes  <= tm_b_ff;
         out_ff.minutes_digit <= m_b_ff;
         out_ff.tens_seconds  <= s10_c;
         out_ff.seconds_digit <= sd_full[3:0];
         out_ff.refresh       <= ref_b_ff;
      end
   end

endmodule

### rtl/core/stopwatch_lap_recall.sv
`timescale 1ns / 1ps
// Top level of the seconds stopwatch with lap memory and recall.
// Depends on slr_pkg, slr_core and slr_digits.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    slr_pkg::req_type  (one poll)
//   rsp_     out        rsp_valid/rsp_ready    slr_pkg::rsp_type  (digits + refresh)
//   csr_     in         csr_valid/csr_ready    csr_wdata, ticks per second
//
// One poll accepted per cycle while rsp_ is not stalled; each result passes through
// the control stage, then three digit stages, one reciprocal multiply each.
// The stopwatch state updates at the poll's transfer, so back-to-back polls see it.
// Synchronous active-high reset clears all but data regs; threshold returns to 1000.
// A stall on rsp_ fills the pipeline, then drops req_ready; csr_ready is always high.
module stopwatch_lap_recall #(
   parameter int unsigned LAP_SLOTS = slr_pkg::LAP_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_wdata,
   input  logic             req_valid,
   output logic             req_ready,
   input  slr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output slr_pkg::rsp_type rsp_data
);
   import slr_pkg::*;

   logic      cnt_valid;
   logic      cnt_ready;
   count_type cnt_data;

   slr_core #(
      .LAP_SLOTS(LAP_SLOTS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .cnt_valid(cnt_valid),
      .cnt_ready(cnt_ready),
      .cnt_data (cnt_data)
   );

   slr_digits u_digits (
      .clock    (clock),
      .reset    (reset),
      .cnt_valid(cnt_valid),
      .cnt_ready(cnt_ready),
      .cnt_data (cnt_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule
